// File: rtl/lwgcd_pkg.sv
// Package: sizes, mode codes and sequencer states for the wait-graph cycle detector.
`timescale 1ns / 1ps
package lwgcd_pkg;
  localparam int ThreadSlots = 64;
  localparam int LockCount   = 256;
  localparam int MaxHops     = 16;
  localparam int SlotW = $clog2(ThreadSlots);
  localparam int LockW = $clog2(LockCount);
  localparam int HopW  = $clog2(MaxHops);

  typedef enum logic [1:0] {
    MODE_ENTER = 2'd0,
    MODE_EXIT  = 2'd1,
    MODE_OWNER = 2'd2,
    MODE_FIND  = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    REG_STALE = 1'd0,
    REG_HOPS  = 1'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_CLAIM, ST_UPD_RD, ST_UPDATE, ST_OWNER, ST_OWN_RD, ST_WALK_RD,
    ST_WALK_CHK, ST_WSCAN, ST_WREAD, ST_WCHK, ST_EMIT_RD, ST_EMIT, ST_DONE
  } state_t;
endpackage

// File: rtl/lock_wait_graph_cycle_detector.sv
// Top level: lock wait-for graph with slot table, owner table and cycle walk.
`timescale 1ns / 1ps
// Sequence: enter/exit scan the slot table, then claim a slot if needed and update it;
//   set-owner writes the owner table; find-cycle scans for the thread, then per hop
//   reads the owner, scans for it and checks its wait edge, then emits the results.
// Throughput: one item at a time; the slot scan (one slot compared per cycle
//   by the shared compare) and the hop walk set the figure. Not ready while busy.
// Reset (rst, synchronous): a clearing pass zeroes the owner memory and slot
//   tables (one entry a cycle); no item accepted meanwhile.
module lock_wait_graph_cycle_detector (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: mode[1:0], thread_id[33:2], lock_id[41:34], lock_valid[42],
  //        new_owner_id[74:43], now_ms[122:75], zero fill to 128
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: accepted[0], edge_changed[1], cycle_found[2], waiter_id[34:3],
  //        waited_lock[42:35], holder_id[74:43], cycle_length[79:75], fill to 80
  output logic [79:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import lwgcd_pkg::*;

  state_t state, state_next;
  logic [15:0] stale_limit;
  logic [4:0]  hop_limit;

  // tables (memories)
  logic [31:0] slot_thread [ThreadSlots];
  logic [8:0]  slot_wait   [ThreadSlots];
  logic [47:0] slot_seen   [ThreadSlots];
  logic [31:0] lock_holder [LockCount];
  logic [71:0] cyc_buf     [MaxHops];

  // clearing pass
  logic         clearing;
  logic [LockW:0] clr_cnt;

  // item registers
  mode_t       mode;
  logic [31:0] tid, own_new;
  logic [7:0]  lock;
  logic        lvalid;
  logic [47:0] now;

  // scan
  logic [SlotW:0] idx;
  logic [SlotW-1:0] hit_slot;
  logic           hit_found, empty_found;
  logic [SlotW-1:0] empty_slot;
  logic [31:0] key;          // thread id searched by the shared compare
  logic [31:0] rd_thread;    // registered slot read
  logic [8:0]  rd_wait;
  logic [47:0] rd_seen;
  logic [31:0] rd_owner;

  // walk
  logic [31:0] waiter, owner;
  logic [7:0]  wlock;
  logic [HopW:0] len;
  logic [4:0]  hops;
  logic        accepted, edge_chg;
  logic [HopW:0] emit_k;
  logic [71:0] rd_cyc;
  logic        out_full;

  logic scan_match;
  logic [SlotW-1:0] cur;

  assign cur = idx[SlotW-1:0];
  assign scan_match = (rd_thread == key);
  assign s_tready  = (state == ST_IDLE) && !clearing;
  // registers change only between requests
  assign cfg_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= 16'd50;
      hop_limit   <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STALE: stale_limit <= cfg_data;
        REG_HOPS:  hop_limit   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == (LockW+1)'(LockCount - 1)) clearing <= 1'b0;
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tready && s_tvalid) begin
        priority case (mode_t'(s_tdata[1:0]))
          MODE_OWNER: state_next = ST_OWNER;
          MODE_FIND:  state_next = ST_SCAN;
          default:    state_next = (s_tdata[33:2] == '0) ? ST_DONE : ST_SCAN;
        endcase
      end
      ST_SCAN: begin
        if (idx != '0 && scan_match) begin
          state_next = (mode == MODE_FIND) ? ST_OWN_RD : ST_UPD_RD;
        end else if (idx == (SlotW+1)'(ThreadSlots)) begin
          state_next = (mode == MODE_FIND) ? ST_OWN_RD : ST_CLAIM;
        end
      end
      ST_CLAIM:   state_next = empty_found ? ST_UPD_RD : ST_DONE;
      ST_UPD_RD:  state_next = ST_UPDATE;  // old wait word of the slot is read here
      ST_UPDATE:  state_next = ST_DONE;
      ST_OWNER:   state_next = ST_DONE;
      ST_OWN_RD:  state_next = (!lvalid || hops == '0) ? ST_DONE : ST_WALK_RD;
      ST_WALK_RD: state_next = ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (rd_owner == '0) state_next = ST_DONE;
        else if (rd_owner == tid)
          state_next = (len + 1'b1 >= (HopW+1)'(2)) ? ST_EMIT_RD : ST_DONE;
        else if ({1'b0, len} + 1'b1 >= (HopW+2)'(hops)) state_next = ST_DONE;
        else state_next = ST_WSCAN;
      end
      ST_WSCAN: begin
        if (idx != '0 && scan_match) state_next = ST_WREAD;
        else if (idx == (SlotW+1)'(ThreadSlots)) state_next = ST_DONE;
      end
      ST_WREAD: state_next = ST_WCHK;
      ST_WCHK: begin
        if (!rd_wait[8] || (now > rd_seen && (now - rd_seen) > {32'd0, stale_limit}))
          state_next = ST_DONE;
        else state_next = ST_WALK_RD;
      end
      ST_EMIT_RD: state_next = ST_EMIT;
      ST_EMIT: if (!out_full || m_tready) begin
        state_next = (emit_k == len - 1'b1) ? ST_IDLE : ST_EMIT_RD;
      end
      ST_DONE: if (!out_full || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (clearing) begin
      lock_holder[clr_cnt[LockW-1:0]] <= '0;
      if (clr_cnt < (LockW+1)'(ThreadSlots)) begin
        slot_thread[clr_cnt[SlotW-1:0]] <= '0;
        slot_wait[clr_cnt[SlotW-1:0]]   <= '0;
        slot_seen[clr_cnt[SlotW-1:0]]   <= '0;
      end
    end
    // registered slot read at the scan index; shared compare uses it next cycle
    rd_thread <= slot_thread[cur];
    rd_wait   <= slot_wait[hit_slot];
    rd_seen   <= slot_seen[hit_slot];
    rd_owner  <= lock_holder[wlock];
    rd_cyc    <= cyc_buf[emit_k[HopW-1:0]];

    unique case (state)
      ST_IDLE: if (s_tready && s_tvalid) begin
        mode    <= mode_t'(s_tdata[1:0]);
        tid     <= s_tdata[33:2];
        lock    <= s_tdata[41:34];
        lvalid  <= s_tdata[42];
        own_new <= s_tdata[74:43];
        now     <= s_tdata[122:75];
        key     <= s_tdata[33:2];
        wlock   <= s_tdata[41:34];
        waiter  <= s_tdata[33:2];
        idx     <= '0;
        hit_found   <= 1'b0;
        empty_found <= 1'b0;
        accepted    <= 1'b0;
        edge_chg    <= 1'b0;
        len         <= '0;
        emit_k      <= '0;
        hops <= (hop_limit < 5'(MaxHops)) ? hop_limit : 5'(MaxHops);
      end
      ST_SCAN, ST_WSCAN: begin
        // idx leads the compared slot by one
        if (idx != '0) begin
          if (scan_match && !hit_found) begin
            hit_found <= 1'b1;
            hit_slot  <= cur - 1'b1;
          end
          if (rd_thread == '0 && !empty_found) begin
            empty_found <= 1'b1;
            empty_slot  <= cur - 1'b1;
          end
        end
        if (!(idx != '0 && scan_match)) idx <= idx + 1'b1;
        if (state == ST_SCAN && idx != '0 && scan_match && mode == MODE_FIND)
          accepted <= (tid != '0);
      end
      ST_CLAIM: if (empty_found) begin
        hit_slot <= empty_slot;
        slot_thread[empty_slot] <= tid;
      end
      ST_UPDATE: begin
        accepted <= 1'b1;
        if (mode == MODE_ENTER) begin
          edge_chg <= (rd_wait != (lvalid ? {1'b1, lock} : 9'd0));
          slot_wait[hit_slot] <= lvalid ? {1'b1, lock} : 9'd0;
          slot_seen[hit_slot] <= now;
        end else begin
          slot_wait[hit_slot] <= '0;
        end
      end
      ST_OWNER: if (lvalid) begin
        lock_holder[lock] <= own_new;
        accepted <= 1'b1;
      end
      ST_WALK_CHK: if (rd_owner != '0) begin
        cyc_buf[len[HopW-1:0]] <= {waiter, wlock, rd_owner};
        len    <= len + 1'b1;
        owner  <= rd_owner;
        key    <= rd_owner;
        idx    <= '0;
        hit_found <= 1'b0;
      end
      ST_WCHK: begin
        waiter <= owner;
        wlock  <= rd_wait[7:0];
      end
      ST_EMIT: if (!out_full || m_tready) emit_k <= emit_k + 1'b1;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else begin
      if (m_tready) out_full <= 1'b0;
      if ((state == ST_DONE || state == ST_EMIT) && (!out_full || m_tready))
        out_full <= 1'b1;
    end
    if ((state == ST_DONE || state == ST_EMIT) && (!out_full || m_tready)) begin
      if (state == ST_DONE) begin
        m_tdata <= {5'd0, 32'd0, 8'd0, 32'd0, 1'b0, edge_chg, accepted};
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= {5'(len), rd_cyc[31:0], rd_cyc[39:32], rd_cyc[71:40],
                    1'b1, 1'b0, accepted};
        m_tlast <= (emit_k == len - 1'b1);
      end
    end
  end
  assign m_tvalid = out_full;

endmodule

// File: tb/tb_lock_wait_graph_cycle_detector.sv
// Testbench: directed and random checks of the lock wait-graph cycle detector.
`timescale 1ns / 1ps
module tb_lock_wait_graph_cycle_detector;
  import lwgcd_pkg::*;

  localparam int IdleLimit = 20000;  // must outlast the slowest walk plus stalls

  typedef struct packed {
    logic        accepted;
    logic        edge_changed;
    logic        cycle_found;
    logic [31:0] waiter_id;
    logic [7:0]  waited_lock;
    logic [31:0] holder_id;
    logic [4:0]  cycle_length;
    logic        last;
  } wait_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;
  logic         m_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = REG_STALE;
  logic [15:0]  cfg_data = '0;

  lock_wait_graph_cycle_detector uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---- predictor state: its own copy of the tables and registers ----
  logic [31:0] slot_tid   [ThreadSlots];
  logic [8:0]  slot_wait  [ThreadSlots];  // bit 8: waiting, 7..0: lock
  logic [47:0] slot_stamp [ThreadSlots];
  logic [31:0] owner_tab  [LockCount];
  logic [15:0] stale_ms;
  logic [4:0]  hop_cap;
  logic [31:0] ring_waiter [MaxHops];
  logic [7:0]  ring_lock   [MaxHops];
  logic [31:0] ring_holder [MaxHops];

  wait_result_t owed_results[$];
  int           mismatch_count = 0;
  int           burst_left = 0;
  logic [47:0]  now_clock;
  logic [31:0]  tid_pool[12];

  function automatic int slot_of(logic [31:0] tid);
    for (int i = 0; i < ThreadSlots; i++)
      if (slot_tid[i] == tid) return i;
    return -1;
  endfunction

  // first slot with this id, else first empty one; id zero never gets a slot
  function automatic int claim_slot(logic [31:0] tid);
    int s;
    if (tid == 0) return -1;
    s = slot_of(tid);
    if (s >= 0) return s;
    s = slot_of(32'd0);
    if (s >= 0) slot_tid[s] = tid;
    return s;
  endfunction

  // follow lock -> owner -> owner's fresh wait edge; returns cycle length or 0
  function automatic int trace_cycle(logic [31:0] me, logic [7:0] start, logic [47:0] now);
    int hops;
    int len;
    int s;
    logic [31:0] waiter;
    logic [31:0] owner;
    logic [7:0]  lk;
    hops = (hop_cap < MaxHops) ? hop_cap : MaxHops;
    len = 0;
    waiter = me;
    lk = start;
    for (int h = 0; h < hops; h++) begin
      owner = owner_tab[lk];
      if (owner == 0) return 0;
      ring_waiter[len] = waiter;
      ring_lock[len] = lk;
      ring_holder[len] = owner;
      len++;
      if (owner == me) return (len >= 2) ? len : 0;
      if (len >= hops) return 0;
      s = slot_of(owner);
      if (s < 0) return 0;
      if (!slot_wait[s][8]) return 0;
      // stamps ahead of now count as live
      if (now > slot_stamp[s] && now - slot_stamp[s] > {32'd0, stale_ms}) return 0;
      waiter = owner;
      lk = slot_wait[s][7:0];
    end
    return 0;
  endfunction

  function automatic void predict_wait_graph(mode_t mode, logic [31:0] tid, logic [7:0] lk,
                                             logic lv, logic [31:0] owner, logic [47:0] now);
    wait_result_t r;
    logic [8:0] nw;
    int s;
    int n;
    r = '0;
    r.last = 1'b1;
    case (mode)
      MODE_ENTER: begin
        s = claim_slot(tid);
        if (s >= 0) begin
          nw = lv ? {1'b1, lk} : 9'd0;
          r.accepted = 1'b1;
          r.edge_changed = (slot_wait[s] != nw);
          slot_stamp[s] = now;
          slot_wait[s] = nw;
        end
        owed_results.push_back(r);
      end
      MODE_EXIT: begin
        s = claim_slot(tid);
        if (s >= 0) begin
          r.accepted = 1'b1;
          slot_wait[s] = 9'd0;
        end
        owed_results.push_back(r);
      end
      MODE_OWNER: begin
        if (lv) begin
          owner_tab[lk] = owner;
          r.accepted = 1'b1;
        end
        owed_results.push_back(r);
      end
      default: begin
        r.accepted = (tid != 0 && slot_of(tid) >= 0);
        n = lv ? trace_cycle(tid, lk, now) : 0;
        if (n == 0) owed_results.push_back(r);
        for (int k = 0; k < n; k++) begin
          r.cycle_found = 1'b1;
          r.waiter_id = ring_waiter[k];
          r.waited_lock = ring_lock[k];
          r.holder_id = ring_holder[k];
          r.cycle_length = n[4:0];
          r.last = (k == n - 1);
          owed_results.push_back(r);
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [47:0] got, logic [47:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // ---- sender: one request, then maybe a gap between bursts ----
  task automatic send_request(mode_t mode, logic [31:0] tid, logic [7:0] lk, logic lv,
                              logic [31:0] owner, logic [47:0] now);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, now, owner, lv, lk, tid, mode};
    do @(posedge clk); while (!s_tready);
    predict_wait_graph(mode, tid, lk, lv, owner, now);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain everything outstanding before touching the registers
  task automatic settle();
    s_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_STALE) stale_ms = val;
    else hop_cap = val[4:0];
  endtask

  // ---- result checker ----
  always @(posedge clk) begin
    wait_result_t got;
    wait_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[34:3], m_tdata[42:35],
             m_tdata[74:43], m_tdata[79:75], m_tlast};
      if (owed_results.size() == 0) begin
        flag_mismatch("result with nothing expected");
      end else begin
        want = owed_results.pop_front();
        check_field("accepted", got.accepted, want.accepted);
        check_field("edge_changed", got.edge_changed, want.edge_changed);
        check_field("cycle_found", got.cycle_found, want.cycle_found);
        check_field("waiter_id", got.waiter_id, want.waiter_id);
        check_field("waited_lock", got.waited_lock, want.waited_lock);
        check_field("holder_id", got.holder_id, want.holder_id);
        check_field("cycle_length", got.cycle_length, want.cycle_length);
        check_field("last", got.last, want.last);
      end
    end
  end

  // ---- receiver stall pattern: always ready, coin flip, or rotating mask ----
  int   stall_style = 0;
  int   style_left = 0;
  logic [7:0] stall_mask = 8'hFF;
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_mask <= 8'($urandom);
      style_left <= $urandom_range(50, 200);
    end else begin
      style_left <= style_left - 1;
      stall_mask <= {stall_mask[6:0], stall_mask[7]};
    end
    case (stall_style)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= stall_mask[0];
    endcase
  end

  // ---- watchdog: cycles with no handshake anywhere ----
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("tb_lock_wait_graph_cycle_detector: errors");
      $finish;
    end
  end

  // ---- test tasks ----
  task automatic test_directed();
    logic [31:0] ta;
    logic [31:0] tb;
    ta = 32'hFFFF_FFFF;
    tb = 32'h0000_0001;
    send_request(MODE_ENTER, 32'd0, 8'd3, 1'b1, 32'd0, 48'd0);    // id zero
    send_request(MODE_EXIT, 32'd0, 8'd3, 1'b1, 32'd0, 48'd0);
    send_request(MODE_OWNER, ta, 8'd9, 1'b0, ta, 48'd0);          // null target
    send_request(MODE_OWNER, 32'd0, 8'd255, 1'b1, ta, 48'd0);
    send_request(MODE_ENTER, ta, 8'd255, 1'b1, 32'd0, 48'd0);
    send_request(MODE_ENTER, ta, 8'd255, 1'b1, 32'd0, 48'd10);    // same target
    send_request(MODE_ENTER, ta, 8'hAA, 1'b0, 32'd0, 48'd20);     // null enter
    send_request(MODE_EXIT, ta, 8'd0, 1'b1, 32'd0, 48'd20);
    // two-party deadlock: ta waits lock 1 held by tb, tb waits lock 2 held by ta
    send_request(MODE_OWNER, 32'd0, 8'd1, 1'b1, tb, 48'd30);
    send_request(MODE_OWNER, 32'd0, 8'd2, 1'b1, ta, 48'd30);
    send_request(MODE_ENTER, ta, 8'd1, 1'b1, 32'd0, 48'h7FFF_0000_0000);
    send_request(MODE_ENTER, tb, 8'd2, 1'b1, 32'd0, 48'h7FFF_0000_0000);
    send_request(MODE_FIND, ta, 8'd1, 1'b1, 32'd0, 48'h7FFF_0000_0010);
    send_request(MODE_FIND, ta, 8'd1, 1'b0, 32'd0, 48'h7FFF_0000_0010);
    send_request(MODE_FIND, 32'h5555_AAAA, 8'd1, 1'b1, 32'd0, 48'h7FFF_0000_0010);
    send_request(MODE_FIND, ta, 8'd1, 1'b1, 32'd0, 48'hFFFF_FFFF_FFFF);  // stale edge
    send_request(MODE_FIND, ta, 8'd1, 1'b1, 32'd0, 48'd0);               // clock skew
    send_request(MODE_OWNER, 32'd0, 8'd3, 1'b1, ta, 48'd0);
    send_request(MODE_FIND, ta, 8'd3, 1'b1, 32'd0, 48'd0);               // self hold
    send_request(MODE_OWNER, 32'd0, 8'd1, 1'b1, 32'd0, 48'd0);           // free lock
    send_request(MODE_FIND, ta, 8'd1, 1'b1, 32'd0, 48'h7FFF_0000_0010);
    send_request(MODE_OWNER, 32'd0, 8'd1, 1'b1, tb, 48'd0);
    write_reg(REG_HOPS, 16'd0);                                          // zero hop limit
    send_request(MODE_FIND, ta, 8'd1, 1'b1, 32'd0, 48'h7FFF_0000_0010);
    write_reg(REG_HOPS, 16'd1);
    send_request(MODE_FIND, ta, 8'd1, 1'b1, 32'd0, 48'h7FFF_0000_0010);
  endtask

  // one well-formed ring of waits with random content, or a broken one
  task automatic random_ring();
    logic [31:0] ring[6];
    logic [7:0]  locks[6];
    int k;
    int j;
    int breaker;
    k = $urandom_range(2, 6);
    for (int i = 0; i < k; i++) begin
      do begin
        j = $urandom_range(0, 11);
        ring[i] = tid_pool[j];
        for (int p = 0; p < i; p++) if (ring[p] == ring[i]) ring[i] = 32'd0;
      end while (ring[i] == 0);
      locks[i] = 8'($urandom);
    end
    breaker = ($urandom_range(0, 3) == 0) ? $urandom_range(0, k - 1) : -1;
    for (int i = 0; i < k; i++)
      send_request(MODE_OWNER, $urandom, locks[i], 1'b1,
                   (i == breaker) ? 32'd0 : ring[(i + 1) % k], now_clock);
    for (int i = 0; i < k; i++) begin
      now_clock += $urandom_range(0, 12);
      send_request(MODE_ENTER, ring[i], locks[i], 1'b1, $urandom, now_clock);
    end
    send_request(MODE_FIND, ring[0], locks[0], 1'b1, $urandom,
                 now_clock + $urandom_range(0, 70));
  endtask

  task automatic random_noise();
    mode_t m;
    logic [31:0] tid;
    m = mode_t'($urandom_range(0, 3));
    tid = ($urandom_range(0, 15) == 0) ? 32'd0 : tid_pool[$urandom_range(0, 11)];
    if ($urandom_range(0, 9) == 0) now_clock = 48'({$urandom, $urandom});
    else now_clock += $urandom_range(0, 30);
    send_request(m, tid, 8'($urandom), 1'($urandom_range(0, 1)), $urandom, now_clock);
  endtask

  task automatic test_random_phases();
    logic [15:0] stale_set[5] = '{16'd50, 16'd0, 16'hFFFF, 16'd20, 16'd100};
    logic [15:0] hops_set[5]  = '{16'd16, 16'd2, 16'd31, 16'd3, 16'd16};
    int sent;
    for (int i = 0; i < 12; i++) tid_pool[i] = $urandom | 32'h1;
    tid_pool[0] = 32'hFFFF_FFFF;
    tid_pool[1] = 32'h0000_0001;
    now_clock = 48'({$urandom, $urandom});
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_STALE, stale_set[ph]);
      write_reg(REG_HOPS, hops_set[ph]);
      sent = 0;
      while (sent < 34) begin
        if ($urandom_range(0, 9) < 7) begin
          random_ring();
          sent += 9;
        end else begin
          random_noise();
          sent++;
        end
      end
    end
  endtask

  // fill every slot, then a newcomer must be turned away
  task automatic test_table_full();
    logic [31:0] tid;
    while (slot_of(32'd0) >= 0) begin
      tid = $urandom | 32'h8000_0000;
      if (slot_of(tid) < 0)
        send_request(MODE_ENTER, tid, 8'($urandom), 1'b1, 32'd0, now_clock);
    end
    do tid = $urandom | 32'h1; while (slot_of(tid) >= 0);
    send_request(MODE_ENTER, tid, 8'd7, 1'b1, 32'd0, now_clock);
    send_request(MODE_EXIT, tid, 8'd7, 1'b1, 32'd0, now_clock);
    send_request(MODE_FIND, tid, 8'd7, 1'b1, 32'd0, now_clock);
  endtask

  initial begin
    for (int i = 0; i < ThreadSlots; i++) begin
      slot_tid[i] = '0;
      slot_wait[i] = '0;
      slot_stamp[i] = '0;
    end
    for (int i = 0; i < LockCount; i++) owner_tab[i] = '0;
    stale_ms = 16'd50;
    hop_cap = 5'd16;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_table_full();
    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && owed_results.size() == 0)
      $display("tb_lock_wait_graph_cycle_detector: clean");
    else
      $display("tb_lock_wait_graph_cycle_detector: errors");
    $finish;
  end
endmodule

// File: sim.f
rtl/lwgcd_pkg.sv
rtl/lock_wait_graph_cycle_detector.sv
tb/tb_lock_wait_graph_cycle_detector.sv
